// ===== design/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// shared constants, status codes and controller/datapath interface types
// for the contiguous page allocator
// ----------------------------------------------------------------------------
package cpa_pkg;

    // pool geometry (page size must be a power of two)
    localparam int PAGE_BYTES = 16;
    localparam int NUM_PAGES  = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // field widths
    localparam int REQ_W   = 10;
    localparam int OFF_W   = 9;
    localparam int STS_W   = 2;
    localparam int PCNT_W  = 6;

    // derived widths
    localparam int PG_W        = $clog2(NUM_PAGES);
    localparam int CNT_W       = $clog2(NUM_PAGES + 1);
    localparam int MAX_NEED    = ((2 ** REQ_W) - 1 + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int NEED_RAW_W  = $clog2(MAX_NEED + 1);
    localparam int NEED_W      = (NEED_RAW_W > CNT_W) ? NEED_RAW_W : CNT_W;
    localparam int SUM_W       = ((REQ_W > PAGE_SHIFT) ? REQ_W : PAGE_SHIFT) + 1;

    // result status codes
    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [STS_W-1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [STS_W-1:0] ST_NOT_ALLOC = 2'd3;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             scan_init;
        logic             scan_step;
        logic             mark_init;
        logic             free_init;
        logic             walk_step;
        logic             st_wr;
        logic [STS_W-1:0] st_code;
        logic             emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic alloc;
        logic bad_size;
        logic too_big;
        logic not_alloc;
        logic found;
        logic scan_end;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

// ===== design/contiguous_page_allocator_core.sv =====
// input transfer to result: allocate scans pages up to the end of the first free run
// long enough, then marks its pages; free walks the block's pages; bad size, too large
// or not allocated respond from decode; no space after a full scan
// throughput: one request at a time, next input transfer taken once the result is
// registered; set by the one-page-per-cycle scan and walk, a waiting result holds it off
// reset: synchronous active low; all pages free, all sizes cleared, no result pending
// ----------------------------------------------------------------------------
// contiguous_page_allocator_core
// first-fit allocator over a fixed pool of pages with per-page busy bits and
// a recorded byte size at the first page of each allocation
// ----------------------------------------------------------------------------
module contiguous_page_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [cpa_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [cpa_pkg::OFF_W-1:0]   i_block_offset,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cpa_pkg::STS_W-1:0]   o_status,
    output logic [cpa_pkg::OFF_W-1:0]   o_start_offset,
    output logic [cpa_pkg::PCNT_W-1:0]  o_page_count
);
    import cpa_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: idle -> decode -> scan (allocate only) -> page walk -> response;
    // an input transfer is taken only in idle
    cpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: busy bits and size store, first-fit run counter, walk counter,
    // shared round-up to pages, and the registered result for the output transfer
    cpa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_block_offset  (i_block_offset),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_start_offset  (o_start_offset),
        .o_page_count    (o_page_count)
    );

endmodule

// ===== design/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpa_ctrl
// request sequencer: decode, first-fit scan, page walk and result hand-off
// ----------------------------------------------------------------------------
module cpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cpa_pkg::t_sts i_sts,
    output cpa_pkg::t_cmd o_cmd
);
    import cpa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.alloc) begin
                    if (i_sts.bad_size) begin
                        o_cmd.st_wr   = 1'b1;
                        o_cmd.st_code = ST_BAD_SIZE;
                        n_state       = S_RESP;
                    end else if (i_sts.too_big) begin
                        o_cmd.st_wr   = 1'b1;
                        o_cmd.st_code = ST_NO_SPACE;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else if (i_sts.not_alloc) begin
                    o_cmd.st_wr   = 1'b1;
                    o_cmd.st_code = ST_NOT_ALLOC;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.free_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.st_wr   = 1'b1;
                    o_cmd.st_code = ST_NO_SPACE;
                    n_state       = S_RESP;
                end else if (i_sts.found) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_WALK;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    o_cmd.st_wr   = 1'b1;
                    o_cmd.st_code = ST_OK;
                    n_state       = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/cpa_datapath.sv =====
// ----------------------------------------------------------------------------
// cpa_datapath
// page busy bits, recorded sizes, scan/walk counters and result register
// ----------------------------------------------------------------------------
module cpa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mode,
    input  logic [cpa_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [cpa_pkg::OFF_W-1:0]   i_block_offset,
    input  cpa_pkg::t_cmd               i_cmd,
    output cpa_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cpa_pkg::STS_W-1:0]   o_status,
    output logic [cpa_pkg::OFF_W-1:0]   o_start_offset,
    output logic [cpa_pkg::PCNT_W-1:0]  o_page_count
);
    import cpa_pkg::*;

    // pool state
    logic [NUM_PAGES-1:0] r_busy;
    logic [REQ_W-1:0]     r_size [NUM_PAGES];

    // captured request
    logic              r_mode;
    logic [REQ_W-1:0]  r_bytes;
    logic [OFF_W-1:0]  r_offset;

    // working registers
    logic [CNT_W-1:0]  r_ptr;
    logic [NEED_W-1:0] r_run;
    logic [NEED_W-1:0] r_need;
    logic [NEED_W-1:0] r_left;
    logic [PG_W-1:0]   r_start;
    logic              r_walk_set;
    logic [STS_W-1:0]  r_status;

    // result register
    logic              r_out_valid;
    logic [STS_W-1:0]  r_out_status;
    logic [OFF_W-1:0]  r_out_offset;
    logic [PCNT_W-1:0] r_out_count;

    // decode
    logic [OFF_W-1:0]  free_page_full;
    logic [PG_W-1:0]   free_page;
    logic [REQ_W-1:0]  size_at;
    logic [REQ_W-1:0]  round_in;
    logic [SUM_W-1:0]  round_sum;
    logic [NEED_W-1:0] need;
    logic [CNT_W-1:0]  avail;
    logic [NEED_W-1:0] free_need;
    logic [PG_W-1:0]   ptr_idx;
    logic [NEED_W-1:0] run_inc;
    logic [NEED_W-1:0] start_w;
    logic [PG_W+PAGE_SHIFT-1:0] off_full;

    assign free_page_full = r_offset >> PAGE_SHIFT;
    assign free_page      = free_page_full[PG_W-1:0];
    assign size_at        = r_size[free_page];

    // one rounding unit shared by allocate and free
    assign round_in  = (r_mode == MODE_FREE) ? size_at : r_bytes;
    assign round_sum = SUM_W'(round_in) + SUM_W'(PAGE_BYTES - 1);
    assign need      = NEED_W'(round_sum >> PAGE_SHIFT);

    assign avail     = CNT_W'(NUM_PAGES) - CNT_W'(free_page);
    assign free_need = (need > NEED_W'(avail)) ? NEED_W'(avail) : need;

    assign ptr_idx   = r_ptr[PG_W-1:0];
    assign run_inc   = r_run + NEED_W'(1);
    assign start_w   = NEED_W'(r_ptr) + NEED_W'(1) - r_need;

    assign o_sts.alloc     = (r_mode == MODE_ALLOC);
    assign o_sts.bad_size  = (r_bytes == '0);
    assign o_sts.too_big   = (need > NEED_W'(NUM_PAGES));
    assign o_sts.not_alloc = (free_page_full >= OFF_W'(NUM_PAGES)) || (size_at == '0);
    assign o_sts.found     = !r_busy[ptr_idx] && (run_inc == r_need);
    assign o_sts.scan_end  = (r_ptr == CNT_W'(NUM_PAGES));
    assign o_sts.walk_last = (r_left == NEED_W'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_bytes  <= i_request_bytes;
            r_offset <= i_block_offset;
        end
        if (i_cmd.scan_init) begin
            r_ptr  <= '0;
            r_run  <= '0;
            r_need <= need;
        end
        if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + CNT_W'(1);
            r_run <= r_busy[ptr_idx] ? '0 : run_inc;
        end
        if (i_cmd.mark_init) begin
            r_start    <= start_w[PG_W-1:0];
            r_ptr      <= CNT_W'(start_w);
            r_left     <= r_need;
            r_walk_set <= 1'b1;
        end
        if (i_cmd.free_init) begin
            r_start    <= free_page;
            r_ptr      <= CNT_W'(free_page);
            r_need     <= free_need;
            r_left     <= free_need;
            r_walk_set <= 1'b0;
        end
        if (i_cmd.walk_step) begin
            r_ptr  <= r_ptr + CNT_W'(1);
            r_left <= r_left - NEED_W'(1);
        end
        if (i_cmd.st_wr) begin
            r_status <= i_cmd.st_code;
        end
    end

    // pool state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int i = 0; i < NUM_PAGES; i++) begin
                r_size[i] <= '0;
            end
        end else if (i_cmd.walk_step) begin
            r_busy[ptr_idx] <= r_walk_set;
            if (o_sts.walk_last) begin
                r_size[r_start] <= r_walk_set ? r_bytes : '0;
            end
        end
    end

    // result register
    assign off_full = {r_start, {PAGE_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_status == ST_OK) begin
                r_out_offset <= OFF_W'(off_full);
                r_out_count  <= PCNT_W'(r_need);
            end else begin
                r_out_offset <= '0;
                r_out_count  <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_start_offset = r_out_offset;
    assign o_page_count   = r_out_count;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for contiguous_page_allocator_core: a short table of
// directed requests, then about 1900 random allocate and free requests,
// each result compared against a typed response or a behavioural model of the page pool
// ----------------------------------------------------------------------------
module tb;
    import cpa_pkg::*;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [OFF_W-1:0]  start_offset;
        logic [PCNT_W-1:0] page_count;
    } t_response;

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] bytes;
        logic [OFF_W-1:0] offset;
        logic             known;   // response typed into the row
        t_response        resp;
    } t_request_row;

    localparam int RANDOM_REQUESTS = 1900;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_mode;
    logic [REQ_W-1:0]  i_request_bytes;
    logic [OFF_W-1:0]  i_block_offset;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [STS_W-1:0]  o_status;
    logic [OFF_W-1:0]  o_start_offset;
    logic [PCNT_W-1:0] o_page_count;

    // model of the pool
    logic [NUM_PAGES-1:0] model_busy;
    logic [REQ_W-1:0]     model_size [NUM_PAGES];

    t_response    pending_responses [$];
    t_request_row directed_rows [$];
    int           mismatch_count;
    int           send_quiet_left;
    int           recv_quiet_left;

    contiguous_page_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_block_offset  (i_block_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_start_offset  (o_start_offset),
        .o_page_count    (o_page_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // first-fit allocate or free against the model, updating its state
    function automatic t_response pool_response(input logic m, input logic [REQ_W-1:0] b,
                                                input logic [OFF_W-1:0] o);
        t_response r;
        int        need;
        int        pg;
        int        k;
        bit        fits;
        bit        done;
        r.status       = ST_OK;
        r.start_offset = '0;
        r.page_count   = '0;
        if (m == MODE_ALLOC) begin
            if (b == '0) begin
                r.status = ST_BAD_SIZE;
            end else begin
                need = (int'(b) + PAGE_BYTES - 1) / PAGE_BYTES;
                r.status = ST_NO_SPACE;
                done = 1'b0;
                for (pg = 0; pg + need <= NUM_PAGES && !done; pg++) begin
                    fits = 1'b1;
                    for (k = 0; k < need; k++) begin
                        if (model_busy[pg + k]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (k = 0; k < need; k++) model_busy[pg + k] = 1'b1;
                        model_size[pg]  = b;
                        r.status        = ST_OK;
                        r.start_offset  = OFF_W'(pg * PAGE_BYTES);
                        r.page_count    = PCNT_W'(need);
                        done            = 1'b1;
                    end
                end
            end
        end else begin
            pg = int'(o) / PAGE_BYTES;   // unaligned offsets fall to their page
            if (pg >= NUM_PAGES) begin
                r.status = ST_NOT_ALLOC;
            end else if (model_size[pg] == '0) begin
                r.status = ST_NOT_ALLOC;
            end else begin
                need = (int'(model_size[pg]) + PAGE_BYTES - 1) / PAGE_BYTES;
                if (need > NUM_PAGES - pg) need = NUM_PAGES - pg;
                for (k = 0; k < need; k++) model_busy[pg + k] = 1'b0;
                model_size[pg] = '0;
                r.start_offset = OFF_W'(pg * PAGE_BYTES);
                r.page_count   = PCNT_W'(need);
            end
        end
        return r;
    endfunction

    function automatic t_request_row mk_row(input logic m, input int b, input int o,
                                            input logic k, input logic [STS_W-1:0] st,
                                            input int so, input int pc);
        t_request_row row;
        row.mode              = m;
        row.bytes             = REQ_W'(b);
        row.offset            = OFF_W'(o);
        row.known             = k;
        row.resp.status       = st;
        row.resp.start_offset = OFF_W'(so);
        row.resp.page_count   = PCNT_W'(pc);
        return row;
    endfunction

    // per-item random wait, with occasional runs of back-to-back items
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input t_request_row row);
        int        gap;
        t_response predicted;
        gap = draw_gap(send_quiet_left);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= row.mode;
        i_request_bytes <= row.bytes;
        i_block_offset  <= row.offset;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = pool_response(row.mode, row.bytes, row.offset);
        pending_responses.push_back(row.known ? row.resp : predicted);
        @(negedge i_clk);
    endtask

    // random request: mostly well-formed allocations and frees of live blocks
    function automatic t_request_row random_request();
        t_request_row row;
        int           live [$];
        int           pick;
        int           alloc_share;
        row = mk_row(MODE_ALLOC, 0, $urandom_range(0, 511), 1'b0, ST_OK, 0, 0);
        for (int p = 0; p < NUM_PAGES; p++) begin
            if (model_size[p] != '0) live.push_back(p);
        end
        alloc_share = ($countones(model_busy) < NUM_PAGES / 2) ? 65 : 40;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            row.bytes = '0;                           // zero size
        end else if (pick < 10) begin
            row.mode  = 1'($urandom_range(0, 1));     // noise
            row.bytes = REQ_W'($urandom_range(0, 1023));
        end else if (pick < 10 + alloc_share * 90 / 100) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      row.bytes = REQ_W'($urandom_range(1, 64));
            else if (pick < 9) row.bytes = REQ_W'($urandom_range(1, 256));
            else               row.bytes = REQ_W'($urandom_range(1, 1023));
        end else begin
            row.mode  = MODE_FREE;
            row.bytes = REQ_W'($urandom_range(0, 1023));
            if (live.size() != 0 && $urandom_range(0, 99) < 85) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                row.offset = OFF_W'(pick * PAGE_BYTES +
                                    (($urandom_range(0, 1) == 0) ? 0 :
                                     $urandom_range(0, PAGE_BYTES - 1)));
            end
        end
        return row;
    endfunction

    // result side: random back-pressure and checking at the rising edge
    initial begin
        int        gap;
        t_response want;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(recv_quiet_left);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d offset %0d count %0d",
                         $time, o_status, o_start_offset, o_page_count);
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_start_offset !== want.start_offset) begin
                    $display("%0t: start_offset expected %0d got %0d",
                             $time, want.start_offset, o_start_offset);
                    mismatch_count++;
                end
                if (o_page_count !== want.page_count) begin
                    $display("%0t: page_count expected %0d got %0d",
                             $time, want.page_count, o_page_count);
                    mismatch_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_ALLOC;
        i_request_bytes = '0;
        i_block_offset  = '0;
        mismatch_count  = 0;
        send_quiet_left = 0;
        recv_quiet_left = 0;
        model_busy      = '0;
        for (int p = 0; p < NUM_PAGES; p++) model_size[p] = '0;

        // directed table: fields, then the response where it is obvious
        directed_rows.push_back(mk_row(MODE_ALLOC, 0,    511, 1'b1, ST_BAD_SIZE,  0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  1023, 0,   1'b1, ST_NOT_ALLOC, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 1023, 0,   1'b1, ST_NO_SPACE,  0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 513,  0,   1'b1, ST_NO_SPACE,  0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 512,  0,   1'b1, ST_OK,        0, 32));
        directed_rows.push_back(mk_row(MODE_ALLOC, 1,    0,   1'b1, ST_NO_SPACE,  0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    15,  1'b1, ST_OK,        0, 32));
        directed_rows.push_back(mk_row(MODE_ALLOC, 1,    0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 16,   0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 17,   0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    24,  1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    48,  1'b0, ST_OK, 0, 0));  // inside a run
        directed_rows.push_back(mk_row(MODE_ALLOC, 32,   0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 16,   0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    511, 1'b0, ST_OK, 0, 0));  // idle top page
        directed_rows.push_back(mk_row(MODE_ALLOC, 496,  0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    16,  1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    32,  1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  0,    64,  1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 341,  341, 1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 160,  170, 1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_ALLOC, 682,  0,   1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  682,  352, 1'b0, ST_OK, 0, 0));
        directed_rows.push_back(mk_row(MODE_FREE,  341,  5,   1'b0, ST_OK, 0, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) send_request(directed_rows[n]);
        repeat (RANDOM_REQUESTS) send_request(random_request());
        i_in_valid <= 1'b0;

        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/cpa_pkg.sv
design/cpa_ctrl.sv
design/cpa_datapath.sv
design/contiguous_page_allocator_core.sv
sim/tb.sv
